// ===== hdl/acrb_pkg.sv =====
// ----------------------------------------------------------------------------
// Audio capture ring buffer: shared package
// Command, status and state codes, register indexes and the structs that
// pass between the controller, the sample store and the top level.
// ----------------------------------------------------------------------------
package acrb_pkg;

  localparam int unsigned STORE_DEPTH_DFLT = 4096;

  localparam int unsigned FILL_W  = 13;
  localparam int unsigned SMP_W   = 16;
  localparam int unsigned RIDX_W  = 12;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned SCALE_W = 42;
  localparam int unsigned PROD_W  = 50;
  localparam int unsigned CFG_W   = 32;

  localparam logic [SCALE_W-1:0] MS_PER_S = SCALE_W'(1000);

  typedef enum logic [2:0] {
    CMD_SAMPLE = 3'd0,
    CMD_START  = 3'd1,
    CMD_STOP   = 3'd2,
    CMD_PAUSE  = 3'd3,
    CMD_RESUME = 3'd4,
    CMD_READ   = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_ALREADY = 2'd1,
    STS_WRONG   = 2'd2,
    STS_INVALID = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REC_IDLE    = 2'd0,
    REC_ACTIVE  = 2'd1,
    REC_PAUSED  = 2'd2,
    REC_STOPPED = 2'd3
  } rec_state_e;

  typedef enum logic [2:0] {
    CFG_CIRCULAR = 3'd0,
    CFG_BUF_SIZE = 3'd1,
    CFG_RATE     = 3'd2,
    CFG_MAX_DUR  = 3'd3,
    CFG_MAX_BYTE = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic              circular_mode;
    logic [FILL_W-1:0] buf_len;
    logic [17:0]       rate_hz;
    logic [CNT_W-1:0]  dur_limit_ms;
    logic [CNT_W-1:0]  max_bytes;
  } cfg_t;

  typedef struct packed {
    logic [2:0]        cmd;
    logic [SMP_W-1:0]  sample_value;
    logic              block_end;
    logic [RIDX_W-1:0] read_index;
  } item_t;

  typedef struct packed {
    logic              wr_en;
    logic [FILL_W-1:0] wr_addr;
    logic [SMP_W-1:0]  wr_data;
    logic              rd_en;
    logic [RIDX_W-1:0] rd_addr;
  } store_req_t;

  typedef struct packed {
    status_e           status;
    rec_state_e        state;
    logic [SMP_W-1:0]  peak;
    logic [CNT_W-1:0]  count;
    logic [FILL_W-1:0] fill;
    logic              rd_ok;
    logic              limit_stop;
  } result_t;

endpackage

// ===== hdl/acrb_store.sv =====
// ----------------------------------------------------------------------------
// Audio capture ring buffer: sample store
// Single-port-write, single-port-read sample memory with registered read data.
// ----------------------------------------------------------------------------
module acrb_store import acrb_pkg::*; #(
  parameter int unsigned StoreDepth = STORE_DEPTH_DFLT
) (
  input  logic             clk_i,
  input  store_req_t       req_i,
  output logic [SMP_W-1:0] rd_data_o
);

  localparam int unsigned AW = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;

  logic [SMP_W-1:0] mem_q [StoreDepth];
  logic [SMP_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[AW'(req_i.wr_addr)] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[AW'(req_i.rd_addr)];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hdl/acrb_ctrl.sv =====
// ----------------------------------------------------------------------------
// Audio capture ring buffer: capture controller
// Recording state, write pointer, fill level, sample counter, peak meter and
// the duration and byte limits, updated once per item.
// ----------------------------------------------------------------------------
module acrb_ctrl import acrb_pkg::*; #(
  parameter int unsigned StoreDepth = STORE_DEPTH_DFLT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       adv_i,
  input  item_t      item_i,
  input  cfg_t       cfg_i,
  output store_req_t req_o,
  output result_t    res_o
);

  localparam logic [16:0] DepthV = 17'(StoreDepth);

  rec_state_e          state_q, state_d;
  logic [FILL_W-1:0]   wp_q, wp_d;
  logic [FILL_W-1:0]   fill_q, fill_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [SCALE_W-1:0]  scaled_q, scaled_d;
  logic [SMP_W-1:0]    peak_q, peak_d;

  logic [FILL_W-1:0]   cap;
  logic [SMP_W-1:0]    mag;
  logic [FILL_W-1:0]   ptr0, ptr_inc, ptr_next;
  logic                is_rec, fill_inc, count_inc;
  logic [FILL_W-1:0]   fill_after;
  logic [CNT_W-1:0]    count_after;
  logic [SCALE_W-1:0]  scaled_after;
  logic [PROD_W-1:0]   dur_prod;
  logic                dur_hit, bytes_hit, lstop;
  status_e             status;
  logic                wr_en, rd_en;
  logic [FILL_W-1:0]   wr_addr;

  assign cap = ({4'b0, cfg_i.buf_len} > DepthV) ? DepthV[FILL_W-1:0]
                                                 : cfg_i.buf_len;
  assign is_rec = (state_q == REC_ACTIVE);
  assign mag = item_i.sample_value[SMP_W-1] ? (~item_i.sample_value + 16'd1)
                                            : item_i.sample_value;

  assign ptr0     = (wp_q >= cap) ? '0 : wp_q;
  assign ptr_inc  = ptr0 + 13'd1;
  assign ptr_next = (ptr_inc >= cap) ? '0 : ptr_inc;

  assign fill_inc     = (fill_q < cap);
  assign count_inc    = cfg_i.circular_mode || fill_inc;
  assign fill_after   = fill_inc ? fill_q + 13'd1 : fill_q;
  assign count_after  = (count_inc && count_q != '1) ? count_q + 32'd1 : count_q;
  assign scaled_after = (count_inc && count_q != '1) ? scaled_q + MS_PER_S : scaled_q;

  assign dur_prod  = PROD_W'(cfg_i.dur_limit_ms) * PROD_W'(cfg_i.rate_hz);
  assign dur_hit   = (cfg_i.dur_limit_ms != '0) &&
                     ({8'b0, scaled_after} >= dur_prod);
  assign bytes_hit = (cfg_i.max_bytes != '0) &&
                     ({19'b0, fill_after, 1'b0} >= {1'b0, cfg_i.max_bytes});
  assign lstop     = (item_i.cmd == CMD_SAMPLE) && is_rec && item_i.block_end &&
                     (dur_hit || bytes_hit);

  always_comb begin
    state_d = state_q;
    unique case (item_i.cmd)
      CMD_SAMPLE: begin
        if (lstop) state_d = REC_STOPPED;
      end
      CMD_START: begin
        if (!is_rec && cfg_i.buf_len != '0) state_d = REC_ACTIVE;
      end
      CMD_STOP: begin
        if (state_q == REC_ACTIVE || state_q == REC_PAUSED) state_d = REC_STOPPED;
      end
      CMD_PAUSE: begin
        if (is_rec) state_d = REC_PAUSED;
      end
      CMD_RESUME: begin
        if (state_q == REC_PAUSED) state_d = REC_ACTIVE;
      end
      default: state_d = state_q;
    endcase
  end

  always_comb begin
    wp_d     = wp_q;
    fill_d   = fill_q;
    count_d  = count_q;
    scaled_d = scaled_q;
    peak_d   = peak_q;
    status   = STS_OK;
    wr_en    = 1'b0;
    wr_addr  = fill_q;
    rd_en    = 1'b0;
    unique case (item_i.cmd)
      CMD_SAMPLE: begin
        if (!is_rec) begin
          status = STS_WRONG;
        end else begin
          peak_d   = (mag > peak_q) ? mag : peak_q;
          fill_d   = fill_after;
          count_d  = count_after;
          scaled_d = scaled_after;
          if (cfg_i.circular_mode) begin
            if (cap != '0) begin
              wr_en   = 1'b1;
              wr_addr = ptr0;
              wp_d    = ptr_next;
            end
          end else if (fill_inc) begin
            wr_en = 1'b1;
          end
        end
      end
      CMD_START: begin
        if (is_rec) begin
          status = STS_ALREADY;
        end else begin
          count_d  = '0;
          scaled_d = '0;
          peak_d   = '0;
          if (cfg_i.buf_len == '0) begin
            status = STS_INVALID;
          end else begin
            fill_d = '0;
            wp_d   = '0;
          end
        end
      end
      CMD_STOP: begin
        status = STS_OK;
      end
      CMD_PAUSE: begin
        if (!is_rec) status = STS_WRONG;
      end
      CMD_RESUME: begin
        if (state_q != REC_PAUSED) status = STS_WRONG;
      end
      CMD_READ: begin
        if ({1'b0, item_i.read_index} >= fill_q ||
            {5'b0, item_i.read_index} >= DepthV) begin
          status = STS_INVALID;
        end else begin
          rd_en = 1'b1;
        end
      end
      default: status = STS_INVALID;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= REC_IDLE;
      wp_q     <= '0;
      fill_q   <= '0;
      count_q  <= '0;
      scaled_q <= '0;
      peak_q   <= '0;
    end else if (adv_i) begin
      state_q  <= state_d;
      wp_q     <= wp_d;
      fill_q   <= fill_d;
      count_q  <= count_d;
      scaled_q <= scaled_d;
      peak_q   <= peak_d;
    end
  end

  assign req_o.wr_en   = adv_i && wr_en;
  assign req_o.wr_addr = wr_addr;
  assign req_o.wr_data = item_i.sample_value;
  assign req_o.rd_en   = adv_i && rd_en;
  assign req_o.rd_addr = item_i.read_index;

  assign res_o.status     = status;
  assign res_o.state      = state_d;
  assign res_o.peak       = peak_d;
  assign res_o.count      = count_d;
  assign res_o.fill       = fill_d;
  assign res_o.rd_ok      = rd_en;
  assign res_o.limit_stop = lstop;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    scaled_q == {10'b0, count_q} * MS_PER_S)
    else $error("scaled counter out of step with sample count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    {4'b0, fill_q} <= DepthV)
    else $error("fill level beyond store depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && lstop |=> state_q == REC_STOPPED)
    else $error("limit stop did not end recording");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && item_i.cmd == CMD_START && status == STS_OK
    |=> fill_q == '0 && count_q == '0 && wp_q == '0 && state_q == REC_ACTIVE)
    else $error("start did not clear capture state");

endmodule

// ===== hdl/audio_capture_ring_buffer.sv =====
// ----------------------------------------------------------------------------
// Audio capture ring buffer with peak meter
// Memory-mode capture controller: commands, sample storage, peak and limits.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o) carries one command item: sample,
// start, stop, pause, resume or read. Output channel (out_valid_o /
// out_stall_i) returns exactly one result item per command: status, state
// after the item, peak, sample count, fill, read data and limit-stop flag.
// An accepted item waits in the input register; the controller updates its
// state and the store is written or read as the item moves into the result
// register, from which the result is offered.
// Throughput is one item per cycle while the receiver does not stall, set by
// the single store write port and the one registered read per cycle.
// When the receiver stalls, the result register holds; one more item waits
// in the input register, then in_stall_o rises.
// Reset returns the state to idle and clears pointer, fill, count and peak;
// registers take their defaults (sample rate 16000, others zero). The store
// is not cleared: an entry reads back only after it has been written.
// Configuration writes are taken at any edge with cfg_we_i high.
// ----------------------------------------------------------------------------
module audio_capture_ring_buffer import acrb_pkg::*; #(
  parameter int unsigned StoreDepth = STORE_DEPTH_DFLT
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [2:0]               cfg_idx_i,
  input  logic [CFG_W-1:0]         cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [2:0]               cmd_i,
  input  logic signed [SMP_W-1:0]  sample_value_i,
  input  logic                     block_end_i,
  input  logic [RIDX_W-1:0]        read_index_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [1:0]               status_code_o,
  output logic [1:0]               rec_state_o,
  output logic [SMP_W-1:0]         peak_magnitude_o,
  output logic [CNT_W-1:0]         sample_count_o,
  output logic [FILL_W-1:0]        fill_count_o,
  output logic signed [SMP_W-1:0]  read_data_o,
  output logic                     limit_stop_o
);

  cfg_t             cfg_q;
  logic             s1_valid_q, s1_valid_d;
  item_t            item_q;
  logic             out_valid_q, out_valid_d;
  result_t          res_q;
  result_t          res;
  store_req_t       req;
  logic [SMP_W-1:0] rd_data;
  logic             advance, in_acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.circular_mode <= 1'b0;
      cfg_q.buf_len       <= '0;
      cfg_q.rate_hz       <= 18'd16000;
      cfg_q.dur_limit_ms  <= '0;
      cfg_q.max_bytes     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CIRCULAR: cfg_q.circular_mode <= cfg_wdata_i[0];
        CFG_BUF_SIZE: cfg_q.buf_len       <= cfg_wdata_i[FILL_W-1:0];
        CFG_RATE:     cfg_q.rate_hz       <= cfg_wdata_i[17:0];
        CFG_MAX_DUR:  cfg_q.dur_limit_ms  <= cfg_wdata_i;
        CFG_MAX_BYTE: cfg_q.max_bytes     <= cfg_wdata_i;
        default:      cfg_q               <= cfg_q;
      endcase
    end
  end

  assign advance     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = s1_valid_q && !advance;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign s1_valid_d  = in_acc || (s1_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q.cmd          <= cmd_i;
      item_q.sample_value <= sample_value_i;
      item_q.block_end    <= block_end_i;
      item_q.read_index   <= read_index_i;
    end
    if (advance) begin
      res_q <= res;
    end
  end

  acrb_ctrl #(
    .StoreDepth(StoreDepth)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (advance),
    .item_i (item_q),
    .cfg_i  (cfg_q),
    .req_o  (req),
    .res_o  (res)
  );

  acrb_store #(
    .StoreDepth(StoreDepth)
  ) u_store (
    .clk_i     (clk_i),
    .req_i     (req),
    .rd_data_o (rd_data)
  );

  assign out_valid_o      = out_valid_q;
  assign status_code_o    = res_q.status;
  assign rec_state_o      = res_q.state;
  assign peak_magnitude_o = res_q.peak;
  assign sample_count_o   = res_q.count;
  assign fill_count_o     = res_q.fill;
  assign read_data_o      = res_q.rd_ok ? rd_data : '0;
  assign limit_stop_o     = res_q.limit_stop;

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// Audio capture ring buffer: self-checking testbench
// Drives command items through the valid/stall input channel, predicts each
// result item with an in-bench model of the capture controller (state,
// peak, counts, fill, store contents and limits) and compares every result
// field. A directed table comes first, then random phases with the
// registers reprogrammed between them and random gaps and stalls on both
// channels, including one long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import acrb_pkg::*;

  localparam logic [2:0] CMD_RSVD_A = 3'd6;
  localparam logic [2:0] CMD_RSVD_B = 3'd7;
  localparam int unsigned RAND_ITEMS = 500;
  localparam int unsigned HOLD_CYCLES = 60;

  typedef struct {
    status_e          status;
    rec_state_e       state;
    logic [15:0]      peak;
    logic [31:0]      count;
    logic [12:0]      fill;
    logic [15:0]      rdata;
    logic             lstop;
  } capture_res_t;

  typedef struct {
    bit               is_cfg;
    cfg_idx_e         ci;
    logic [31:0]      cdata;
    logic [2:0]       c;
    logic [15:0]      v;
    bit               b;
    logic [11:0]      idx;
    bit               typed;
    status_e          st;
    rec_state_e       rs;
  } stim_row_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [2:0]              cfg_idx_i;
  logic [CFG_W-1:0]        cfg_wdata_i;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [2:0]              cmd_i;
  logic signed [SMP_W-1:0] sample_value_i;
  logic                    block_end_i;
  logic [RIDX_W-1:0]       read_index_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic [1:0]              status_code_o;
  logic [1:0]              rec_state_o;
  logic [SMP_W-1:0]        peak_magnitude_o;
  logic [CNT_W-1:0]        sample_count_o;
  logic [FILL_W-1:0]       fill_count_o;
  logic signed [SMP_W-1:0] read_data_o;
  logic                    limit_stop_o;

  audio_capture_ring_buffer dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .cmd_i            (cmd_i),
    .sample_value_i   (sample_value_i),
    .block_end_i      (block_end_i),
    .read_index_i     (read_index_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_code_o    (status_code_o),
    .rec_state_o      (rec_state_o),
    .peak_magnitude_o (peak_magnitude_o),
    .sample_count_o   (sample_count_o),
    .fill_count_o     (fill_count_o),
    .read_data_o      (read_data_o),
    .limit_stop_o     (limit_stop_o)
  );

  // capture model state and register copies
  logic             m_circ;
  logic [12:0]      m_bsize;
  logic [17:0]      m_rate;
  logic [31:0]      m_dur;
  logic [31:0]      m_bytes;
  rec_state_e       m_state;
  int               m_wp;
  int               m_fill;
  logic [31:0]      m_count;
  logic [15:0]      m_peak;
  logic [15:0]      store_copy [STORE_DEPTH_DFLT];
  bit               written_copy [STORE_DEPTH_DFLT];

  capture_res_t     pending_results [$];
  stim_row_t        dir_tab [$];
  int               errors;
  int               rand_items;
  bit               tx_burst;
  bit               rx_burst;
  bit               hold_rx;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #200_000;
    $display("tb: failure");
    $finish;
  end

  task automatic capture_reset();
    int i;
    m_circ  = 1'b0;
    m_bsize = '0;
    m_rate  = 18'd16000;
    m_dur   = '0;
    m_bytes = '0;
    m_state = REC_IDLE;
    m_wp    = 0;
    m_fill  = 0;
    m_count = '0;
    m_peak  = '0;
    for (i = 0; i < STORE_DEPTH_DFLT; i++) begin
      store_copy[i]   = '0;
      written_copy[i] = 1'b0;
    end
  endtask

  task automatic count_sample();
    if (m_count != 32'hFFFF_FFFF) m_count++;
  endtask

  task automatic capture_step(input logic [2:0] c, input logic [15:0] raw, input bit blk,
                              input logic [11:0] ridx, output capture_res_t r);
    int          cap;
    logic [16:0] mag;
    bit          stop;
    r.status = STS_OK;
    r.rdata  = '0;
    r.lstop  = 1'b0;
    cap = (m_bsize > STORE_DEPTH_DFLT) ? STORE_DEPTH_DFLT : int'(m_bsize);
    case (c)
      CMD_SAMPLE: begin
        if (m_state != REC_ACTIVE) begin
          r.status = STS_WRONG;
        end else begin
          mag = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
          if (mag > {1'b0, m_peak}) m_peak = mag[15:0];
          if (m_circ) begin
            if (cap != 0) begin
              if (m_wp >= cap) m_wp = 0;
              store_copy[m_wp]   = raw;
              written_copy[m_wp] = 1'b1;
              m_wp++;
              if (m_wp >= cap) m_wp = 0;
              if (m_fill < cap) m_fill++;
            end
            count_sample();
          end else if (m_fill < cap) begin
            store_copy[m_fill]   = raw;
            written_copy[m_fill] = 1'b1;
            m_fill++;
            count_sample();
          end
          if (blk) begin
            stop = 1'b0;
            if (m_dur != 0 && 64'(m_count) * 64'd1000 >= 64'(m_dur) * 64'(m_rate))
              stop = 1'b1;
            if (m_bytes != 0 && 64'(m_fill) * 64'd2 >= 64'(m_bytes)) stop = 1'b1;
            if (stop) begin
              m_state = REC_STOPPED;
              r.lstop = 1'b1;
            end
          end
        end
      end
      CMD_START: begin
        if (m_state == REC_ACTIVE) begin
          r.status = STS_ALREADY;
        end else begin
          m_count = '0;
          m_peak  = '0;
          if (m_bsize == 0) begin
            r.status = STS_INVALID;
          end else begin
            m_fill  = 0;
            m_wp    = 0;
            m_state = REC_ACTIVE;
          end
        end
      end
      CMD_STOP: begin
        if (m_state == REC_ACTIVE || m_state == REC_PAUSED) m_state = REC_STOPPED;
      end
      CMD_PAUSE: begin
        if (m_state != REC_ACTIVE) r.status = STS_WRONG;
        else m_state = REC_PAUSED;
      end
      CMD_RESUME: begin
        if (m_state != REC_PAUSED) r.status = STS_WRONG;
        else m_state = REC_ACTIVE;
      end
      CMD_READ: begin
        if (int'(ridx) >= m_fill) r.status = STS_INVALID;
        else r.rdata = store_copy[ridx];
      end
      default: r.status = STS_INVALID;
    endcase
    r.state = m_state;
    r.peak  = m_peak;
    r.count = m_count;
    r.fill  = 13'(m_fill);
  endtask

  // steer reads away from entries that were never written
  function automatic logic [11:0] safe_index(input logic [11:0] idx);
    int j;
    if (int'(idx) >= m_fill || written_copy[idx]) return idx;
    if (m_fill < STORE_DEPTH_DFLT) return 12'(m_fill);
    for (j = 0; j < m_fill; j++) begin
      if (written_copy[j]) return 12'(j);
    end
    return idx;
  endfunction

  function automatic int draw_wait(input bit burst);
    if (burst) return 0;
    return $urandom_range(0, 4);
  endfunction

  task automatic send_item(input logic [2:0] c, input logic [15:0] v, input bit b,
                           input logic [11:0] idx, input bit typed, input status_e st,
                           input rec_state_e rs);
    capture_res_t r;
    int           gap;
    logic [11:0]  ix;
    ix  = (c == CMD_READ) ? safe_index(idx) : idx;
    gap = draw_wait(tx_burst);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    cmd_i          <= c;
    sample_value_i <= v;
    block_end_i    <= b;
    read_index_i   <= ix;
    capture_step(c, v, b, ix, r);
    if (typed) begin
      r.status = st;
      r.state  = rs;
    end
    pending_results.push_back(r);
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_CIRCULAR: m_circ  = val[0];
      CFG_BUF_SIZE: m_bsize = val[12:0];
      CFG_RATE:     m_rate  = val[17:0];
      CFG_MAX_DUR:  m_dur   = val;
      CFG_MAX_BYTE: m_bytes = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic pick_settings(input int p);
    logic        c;
    logic [12:0] bs;
    logic [17:0] sr;
    logic [31:0] dur;
    logic [31:0] nb;
    c   = 1'($urandom_range(0, 1));
    bs  = ($urandom_range(0, 3) == 0) ? 13'($urandom_range(1, 4096))
                                      : 13'($urandom_range(1, 12));
    if ($urandom_range(0, 7) == 0) bs = '0;
    case ($urandom_range(0, 8))
      0: sr = 18'd1;
      1: sr = 18'd1000;
      2: sr = 18'd8000;
      3: sr = 18'd16000;
      4: sr = 18'd48000;
      5: sr = 18'd192000;
      6: sr = '0;
      7: sr = '1;
      default: sr = 18'($urandom_range(1, 192000));
    endcase
    case ($urandom_range(0, 5))
      2: dur = $urandom_range(1, 20);
      3: dur = '1;
      4: dur = $urandom;
      5: dur = $urandom_range(1, 3);
      default: dur = '0;
    endcase
    case ($urandom_range(0, 4))
      2: nb = $urandom_range(1, 30);
      3: nb = '1;
      4: nb = $urandom;
      default: nb = '0;
    endcase
    case (p)
      0: begin
        c = 1'b1; bs = 13'd1; sr = 18'd192000; dur = '1; nb = '1;
      end
      1: begin
        c = 1'b0; bs = 13'd4096; sr = 18'd1; dur = 32'd1; nb = '0;
      end
      2: begin
        c = 1'b1; bs = 13'd4096; sr = '0; dur = '0; nb = 32'd2;
      end
      3: begin
        c = 1'b1; bs = '0; sr = '1; dur = '0; nb = '0;
      end
      default: ;
    endcase
    write_reg(CFG_CIRCULAR, 32'(c));
    write_reg(CFG_BUF_SIZE, 32'(bs));
    write_reg(CFG_RATE, 32'(sr));
    write_reg(CFG_MAX_DUR, dur);
    write_reg(CFG_MAX_BYTE, nb);
  endtask

  task automatic gen_item(output logic [2:0] c, output logic [15:0] v, output bit b,
                          output logic [11:0] idx);
    int r;
    r = $urandom_range(0, 99);
    case ($urandom_range(0, 31))
      0: v = 16'h8000;
      1: v = 16'h7FFF;
      2: v = 16'h0000;
      3: v = 16'hFFFF;
      default: v = 16'($urandom);
    endcase
    b   = ($urandom_range(0, 3) == 0);
    idx = 12'($urandom_range(0, 4095));
    if (m_state == REC_ACTIVE) begin
      if (r < 66) c = CMD_SAMPLE;
      else if (r < 80) c = CMD_READ;
      else if (r < 85) c = CMD_PAUSE;
      else if (r < 89) c = CMD_STOP;
      else if (r < 92) c = CMD_START;
      else if (r < 95) c = CMD_RESUME;
      else if (r < 97) c = CMD_RSVD_A;
      else c = CMD_RSVD_B;
    end else if (m_state == REC_PAUSED && r < 50) begin
      c = CMD_RESUME;
    end else if (m_state != REC_PAUSED && r < 65) begin
      c = CMD_START;
    end else begin
      c = 3'($urandom_range(0, 7));
    end
    if (c == CMD_READ && m_fill > 0 && $urandom_range(0, 2) != 0)
      idx = 12'($urandom_range(0, m_fill - 1));
  endtask

  function automatic stim_row_t mk_item(input logic [2:0] c, input logic [15:0] v,
                                        input bit b, input logic [11:0] idx, input bit typed,
                                        input status_e st, input rec_state_e rs);
    stim_row_t row;
    row.is_cfg = 1'b0;
    row.ci     = CFG_CIRCULAR;
    row.cdata  = '0;
    row.c      = c;
    row.v      = v;
    row.b      = b;
    row.idx    = idx;
    row.typed  = typed;
    row.st     = st;
    row.rs     = rs;
    return row;
  endfunction

  function automatic stim_row_t mk_cfg(input cfg_idx_e ci, input logic [31:0] d);
    stim_row_t row;
    row        = mk_item(CMD_SAMPLE, '0, 1'b0, '0, 1'b0, STS_OK, REC_IDLE);
    row.is_cfg = 1'b1;
    row.ci     = ci;
    row.cdata  = d;
    return row;
  endfunction

  task automatic check_result();
    capture_res_t e;
    bit           bad;
    if (pending_results.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result item: status %0d state %0d",
                                 status_code_o, rec_state_o);
      return;
    end
    e   = pending_results.pop_front();
    bad = (status_code_o !== e.status) || (rec_state_o !== e.state) ||
          (peak_magnitude_o !== e.peak) || (sample_count_o !== e.count) ||
          (fill_count_o !== e.fill) || (read_data_o !== e.rdata) ||
          (limit_stop_o !== e.lstop);
    if (bad) begin
      errors++;
      if (errors <= 10) begin
        $display("mismatch exp: sts %0d st %0d peak %0d cnt %0d fill %0d rd %h lim %0d",
                 e.status, e.state, e.peak, e.count, e.fill, e.rdata, e.lstop);
        $display("         got: sts %0d st %0d peak %0d cnt %0d fill %0d rd %h lim %0d",
                 status_code_o, rec_state_o, peak_magnitude_o, sample_count_o,
                 fill_count_o, read_data_o, limit_stop_o);
      end
    end
  endtask

  // result side: random stall per item, plus the long hold-off
  initial begin
    int rx_wait;
    out_stall_i = 1'b0;
    rx_wait     = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
        check_result();
        rx_wait = draw_wait(rx_burst);
      end
      @(negedge clk_i);
      if (rx_wait > 0) begin
        out_stall_i <= 1'b1;
        rx_wait--;
      end else begin
        out_stall_i <= hold_rx;
      end
    end
  end

  initial begin
    hold_rx = 1'b0;
    wait (rand_items >= 250);
    @(posedge clk_i);
    hold_rx = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_rx = 1'b0;
  end

  initial begin
    logic [2:0]  c;
    logic [15:0] v;
    bit          b;
    logic [11:0] idx;
    int          phase;
    int          n;
    int          guard;
    stim_row_t   row;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_CIRCULAR;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    cmd_i          = CMD_SAMPLE;
    sample_value_i = '0;
    block_end_i    = 1'b0;
    read_index_i   = '0;
    errors         = 0;
    rand_items     = 0;
    tx_burst       = 1'b0;
    rx_burst       = 1'b0;
    capture_reset();

    dir_tab.push_back(mk_item(CMD_SAMPLE, 16'h1234, 1'b1, '0, 1'b1, STS_WRONG, REC_IDLE));
    dir_tab.push_back(mk_item(CMD_PAUSE, '0, 1'b0, '0, 1'b1, STS_WRONG, REC_IDLE));
    dir_tab.push_back(mk_item(CMD_RESUME, '0, 1'b0, '0, 1'b1, STS_WRONG, REC_IDLE));
    dir_tab.push_back(mk_item(CMD_STOP, '0, 1'b0, '0, 1'b1, STS_OK, REC_IDLE));
    dir_tab.push_back(mk_item(CMD_START, '0, 1'b0, '0, 1'b1, STS_INVALID, REC_IDLE));
    dir_tab.push_back(mk_item(CMD_READ, '0, 1'b0, '0, 1'b1, STS_INVALID, REC_IDLE));
    dir_tab.push_back(mk_item(CMD_RSVD_A, '0, 1'b0, '0, 1'b1, STS_INVALID, REC_IDLE));
    dir_tab.push_back(mk_item(CMD_RSVD_B, '1, 1'b1, '1, 1'b1, STS_INVALID, REC_IDLE));
    dir_tab.push_back(mk_cfg(CFG_BUF_SIZE, 32'd4));
    dir_tab.push_back(mk_item(CMD_START, '0, 1'b0, '0, 1'b1, STS_OK, REC_ACTIVE));
    dir_tab.push_back(mk_item(CMD_START, '0, 1'b0, '0, 1'b1, STS_ALREADY, REC_ACTIVE));
    dir_tab.push_back(mk_item(CMD_SAMPLE, 16'h8000, 1'b0, '0, 1'b1, STS_OK, REC_ACTIVE));
    dir_tab.push_back(mk_item(CMD_SAMPLE, 16'h7FFF, 1'b0, '0, 1'b1, STS_OK, REC_ACTIVE));
    dir_tab.push_back(mk_item(CMD_PAUSE, '0, 1'b0, '0, 1'b1, STS_OK, REC_PAUSED));
    dir_tab.push_back(mk_item(CMD_SAMPLE, 16'hFFFF, 1'b1, '0, 1'b1, STS_WRONG, REC_PAUSED));
    dir_tab.push_back(mk_item(CMD_RESUME, '0, 1'b0, '0, 1'b1, STS_OK, REC_ACTIVE));
    dir_tab.push_back(mk_item(CMD_SAMPLE, 16'hFFFF, 1'b0, '0, 1'b1, STS_OK, REC_ACTIVE));
    dir_tab.push_back(mk_item(CMD_SAMPLE, 16'h0000, 1'b0, '0, 1'b1, STS_OK, REC_ACTIVE));
    dir_tab.push_back(mk_item(CMD_SAMPLE, 16'h0005, 1'b1, '0, 1'b1, STS_OK, REC_ACTIVE));
    dir_tab.push_back(mk_item(CMD_READ, '0, 1'b0, 12'd0, 1'b0, STS_OK, REC_IDLE));
    dir_tab.push_back(mk_item(CMD_READ, '0, 1'b0, 12'd3, 1'b0, STS_OK, REC_IDLE));
    dir_tab.push_back(mk_item(CMD_READ, '0, 1'b0, 12'd4, 1'b1, STS_INVALID, REC_ACTIVE));
    dir_tab.push_back(mk_item(CMD_READ, '0, 1'b0, 12'd4095, 1'b1, STS_INVALID, REC_ACTIVE));
    dir_tab.push_back(mk_item(CMD_STOP, '0, 1'b0, '0, 1'b1, STS_OK, REC_STOPPED));
    dir_tab.push_back(mk_cfg(CFG_MAX_BYTE, 32'd4));
    dir_tab.push_back(mk_item(CMD_START, '0, 1'b0, '0, 1'b1, STS_OK, REC_ACTIVE));
    dir_tab.push_back(mk_item(CMD_SAMPLE, 16'h7FFF, 1'b0, '0, 1'b1, STS_OK, REC_ACTIVE));
    dir_tab.push_back(mk_item(CMD_SAMPLE, 16'h8001, 1'b1, '0, 1'b1, STS_OK, REC_STOPPED));

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_tab[i]) begin
      row = dir_tab[i];
      if (row.is_cfg) begin
        wait_idle();
        write_reg(row.ci, row.cdata);
      end else begin
        send_item(row.c, row.v, row.b, row.idx, row.typed, row.st, row.rs);
      end
    end

    phase = 0;
    while (rand_items < RAND_ITEMS) begin
      wait_idle();
      pick_settings(phase);
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      n = $urandom_range(15, 60);
      repeat (n) begin
        gen_item(c, v, b, idx);
        rand_items++;
        send_item(c, v, b, idx, 1'b0, STS_OK, REC_IDLE);
      end
      phase++;
    end

    in_valid_i <= 1'b0;
    guard = 0;
    while (pending_results.size() != 0 && guard < 20000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (10) @(negedge clk_i);
    errors += pending_results.size();
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
